// File: rtl/core/eab_pkg.sv
// Shared types, widths and constants for the emission angle bounds block.
`default_nettype none

package eab_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 18;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int COORD_W    = 32;
    localparam int LEN_W      = 31;
    localparam int OUT_W      = 20;
    localparam int DIFF_W     = 34;
    localparam int DIST_W     = 33;
    localparam int DEN_W      = 32;
    localparam int LEG_W      = 31;
    localparam int SQR_W      = 62;
    localparam int SUMSQ_W    = 63;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 64;
    localparam int OPND_W     = 34;
    localparam int NORM_W     = 41;
    localparam int NORM_STEPS = 6;
    localparam int CRD_W      = 45;
    localparam int ANG_W      = 33;
    localparam int SUM_W      = 36;
    localparam int ANG_Q      = 30;

    localparam logic [ANG_W-1:0] PI_Q30      = 33'd3373259426;
    localparam logic [ANG_W-1:0] HALF_PI_Q30 = 33'd1686629713;

    localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
        33'd843314857, 33'd497837829, 33'd263043837, 33'd133525159,
        33'd67021687,  33'd33543515,  33'd16775850,  33'd8388438,
        33'd4194283,   33'd2097149,   33'd1048576,   33'd524288,
        33'd262144,    33'd131072,    33'd65536,     33'd32768,
        33'd16384,     33'd8192,      33'd4096,      33'd2048,
        33'd1024,      33'd512,       33'd256,       33'd128,
        33'd64,        33'd32,        33'd16,        33'd8,
        33'd4,         33'd2,         33'd1,         33'd0
    };

    typedef enum logic [2:0] {
        XR_EQ_POS,
        XR_EQ_NEG,
        XR_ABOVE,
        XR_BELOW,
        XR_INSIDE
    } xreg_t;

    typedef enum logic [1:0] {
        YR_MID,
        YR_HI,
        YR_LO
    } yreg_t;

    typedef enum logic [1:0] {
        AT_NORMAL,
        AT_ZERO,
        AT_RIGHT
    } atsp_t;

    typedef struct packed {
        xreg_t xr;
        yreg_t yr;
    } region_t;

    typedef struct packed {
        logic [DIST_W-1:0] d1;
        logic [DIST_W-1:0] d2;
        logic [DIST_W-1:0] d3;
        logic [DIST_W-1:0] d4;
        logic [DEN_W-1:0]  den;
        logic              xo;
        logic              yo;
        region_t           rg;
    } item_t;

    typedef struct packed {
        item_t             it;
        logic [DIST_W-1:0] min12;
        logic [DIST_W-1:0] min34;
        logic [DIST_W-1:0] tover;
    } geom_t;

endpackage

`default_nettype wire

// File: rtl/core/eab_front.sv
// Front end: accepts points, forms edge distances and classifies the region.
`default_nettype none

module eab_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [eab_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [eab_pkg::COORD_W-1:0] pos_y,
    input  wire logic [eab_pkg::LEN_W-1:0]    height_z,
    input  wire logic [eab_pkg::LEN_W-1:0]    side_len,
    output logic                              q_push,
    output eab_pkg::item_t                    q_item,
    input  wire logic                         q_full
);
    import eab_pkg::*;

    logic                      adv;
    logic                      f1_vld_reg;
    logic                      f1_vld_next;
    logic                      f2_vld_reg;
    logic                      f2_vld_next;
    logic signed [DIFF_W-1:0]  x2;
    logic signed [DIFF_W-1:0]  y2;
    logic signed [DIFF_W-1:0]  w;
    logic signed [DIFF_W-1:0]  dxm_reg;
    logic signed [DIFF_W-1:0]  dxp_reg;
    logic signed [DIFF_W-1:0]  dym_reg;
    logic signed [DIFF_W-1:0]  dyp_reg;
    logic [DEN_W-1:0]          den_reg;
    item_t                     item_reg;
    item_t                     item_next;

    function automatic logic [DIST_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        n = -v;
        return v[DIFF_W-1] ? n[DIST_W-1:0] : v[DIST_W-1:0];
    endfunction

    assign adv    = !(f2_vld_reg && q_full);
    assign full   = !adv;
    assign q_push = f2_vld_reg && !q_full;
    assign q_item = item_reg;

    assign x2 = {pos_x[COORD_W-1], pos_x, 1'b0};
    assign y2 = {pos_y[COORD_W-1], pos_y, 1'b0};
    assign w  = {{(DIFF_W-LEN_W){1'b0}}, side_len};

    assign f1_vld_next = adv ? push : f1_vld_reg;
    assign f2_vld_next = adv ? f1_vld_reg : f2_vld_reg;

    always_comb
    begin
        item_next.d1  = mag(dxm_reg);
        item_next.d2  = mag(dxp_reg);
        item_next.d3  = mag(dym_reg);
        item_next.d4  = mag(dyp_reg);
        item_next.den = den_reg;
        item_next.xo  = (dxm_reg > 0) || (dxp_reg < 0);
        item_next.yo  = (dym_reg > 0) || (dyp_reg < 0);
        if (dxm_reg == '0)
            item_next.rg.xr = XR_EQ_POS;
        else if (dxp_reg == '0)
            item_next.rg.xr = XR_EQ_NEG;
        else if (dxm_reg > 0)
            item_next.rg.xr = XR_ABOVE;
        else if (dxp_reg < 0)
            item_next.rg.xr = XR_BELOW;
        else
            item_next.rg.xr = XR_INSIDE;
        if ((dyp_reg > 0) && (dym_reg < 0))
            item_next.rg.yr = YR_MID;
        else if (dym_reg >= 0)
            item_next.rg.yr = YR_HI;
        else
            item_next.rg.yr = YR_LO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= f1_vld_next;
            f2_vld_reg <= f2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxm_reg  <= x2 - w;
            dxp_reg  <= x2 + w;
            dym_reg  <= y2 - w;
            dyp_reg  <= y2 + w;
            den_reg  <= {height_z, 1'b0};
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/eab_fifo.sv
// Small queue between the front end and the back end.
`default_nettype none

module eab_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = eab_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [AW-1:0]    rp_reg;
    logic [AW-1:0]    rp_next;
    logic [AW:0]      cnt_reg;
    logic [AW:0]      cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

`default_nettype wire

// File: rtl/core/eab_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module eab_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [eab_pkg::SUMSQ_W-1:0]   rad,
    output logic [eab_pkg::ROOT_W-1:0]         root
);
    import eab_pkg::*;

    logic [REM_W-1:0]  rem_reg [ROOT_W];
    logic [ROOT_W-1:0] rt_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  term;
        logic [ROOT_W-1:0] rt_in;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_W'(rad);
            assign rt_in  = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign rt_in  = rt_reg[s-1];
        end

        assign term = (REM_W'(rt_in) << (B + 1)) | (REM_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= term)
                begin
                    rem_reg[s] <= rem_in - term;
                    rt_reg[s]  <= rt_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[s] <= rem_in;
                    rt_reg[s]  <= rt_in;
                end
            end
        end
    end

    assign root = rt_reg[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/eab_atan.sv
// Pipelined atan2 of magnitudes: normalizing shifter then vectoring CORDIC.
`default_nettype none

module eab_atan #(
    parameter int CORDIC_STEPS = eab_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [eab_pkg::OPND_W-1:0]  num,
    input  wire logic [eab_pkg::OPND_W-1:0]  den,
    output logic signed [eab_pkg::ANG_W-1:0] ang
);
    import eab_pkg::*;

    localparam int LAT = 1 + NORM_STEPS + CORDIC_STEPS;

    logic [NORM_W-1:0]        nn_reg [NORM_STEPS+1];
    logic [NORM_W-1:0]        dd_reg [NORM_STEPS+1];
    logic [NORM_W-1:0]        mm_reg [NORM_STEPS+1];
    logic signed [CRD_W-1:0]  x_reg  [CORDIC_STEPS];
    logic signed [CRD_W-1:0]  y_reg  [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  z_reg  [CORDIC_STEPS];
    atsp_t                    sp_reg [LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn_reg[0] <= NORM_W'(num);
            dd_reg[0] <= NORM_W'(den);
            mm_reg[0] <= (num > den) ? NORM_W'(num) : NORM_W'(den);
            if (num == '0)
                sp_reg[0] <= AT_ZERO;
            else if (den == '0)
                sp_reg[0] <= AT_RIGHT;
            else
                sp_reg[0] <= AT_NORMAL;
            for (int i = 1; i < LAT; i++)
                sp_reg[i] <= sp_reg[i-1];
        end
    end

    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic hit;

        assign hit = (mm_reg[k][NORM_W-1 -: SH] == '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nn_reg[k+1] <= hit ? (nn_reg[k] << SH) : nn_reg[k];
                dd_reg[k+1] <= hit ? (dd_reg[k] << SH) : dd_reg[k];
                mm_reg[k+1] <= hit ? (mm_reg[k] << SH) : mm_reg[k];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CRD_W-1:0] xi;
        logic signed [CRD_W-1:0] yi;
        logic signed [ANG_W-1:0] zi;
        logic signed [ANG_W-1:0] step;

        if (i == 0)
        begin : g_first
            assign xi = signed'({{(CRD_W-NORM_W){1'b0}}, dd_reg[NORM_STEPS]});
            assign yi = signed'({{(CRD_W-NORM_W){1'b0}}, nn_reg[NORM_STEPS]});
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign step = signed'(ATAN_TAB[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi >= 0)
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + step;
                end
                else
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - step;
                end
            end
        end
    end

    always_comb
    begin
        unique case (sp_reg[LAT-1])
            AT_ZERO:  ang = '0;
            AT_RIGHT: ang = signed'(HALF_PI_Q30);
            default:  ang = z_reg[CORDIC_STEPS-1];
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/eab_back.sv
// Back end: corner distances, square roots, six arctangents, bound selection.
`default_nettype none

module eab_back #(
    parameter int FRACTION_BITS = eab_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = eab_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire eab_pkg::item_t              q_item,
    output logic                             q_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic signed [eab_pkg::OUT_W-1:0] zenith_max,
    output logic signed [eab_pkg::OUT_W-1:0] zenith_min,
    output logic signed [eab_pkg::OUT_W-1:0] azimuth_max,
    output logic signed [eab_pkg::OUT_W-1:0] azimuth_min
);
    import eab_pkg::*;

    localparam int ATAN_LAT = 1 + NORM_STEPS + CORDIC_STEPS;
    localparam int LAT      = 4 + ROOT_W + 1 + ATAN_LAT + 2;
    localparam int SH       = ANG_Q - FRACTION_BITS;

    localparam logic signed [SUM_W-1:0] PI_S     = SUM_W'(PI_Q30);
    localparam logic signed [SUM_W-1:0] HALF_S   = SUM_W'(HALF_PI_Q30);
    localparam logic signed [SUM_W-1:0] THREE_H  = PI_S + HALF_S;
    localparam logic signed [SUM_W-1:0] TWO_PI   = PI_S + PI_S;
    localparam logic signed [SUM_W-1:0] RND      = SUM_W'(1) << (SH - 1);
    localparam logic signed [SUM_W-1:0] OMAX     = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OMIN     = -OMAX - SUM_W'(1);

    logic                     badv;
    logic [LAT-1:0]           vld_reg;
    logic [LAT-1:0]           vld_next;

    logic [LEG_W-1:0]         leg [4];
    item_t                    it1_reg;
    logic [SQR_W-1:0]         sq_reg [4];
    logic [DIST_W-1:0]        mn12_reg;
    logic [DIST_W-1:0]        mn34_reg;
    geom_t                    g2_reg;
    logic [SUMSQ_W-1:0]       sum_reg [4];
    geom_t                    g3_reg;
    logic [SUMSQ_W-1:0]       mx01_reg;
    logic [SUMSQ_W-1:0]       mn01_reg;
    logic [SUMSQ_W-1:0]       mx23_reg;
    logic [SUMSQ_W-1:0]       mn23_reg;
    geom_t                    g4_reg;
    logic [SUMSQ_W-1:0]       smax_reg;
    logic [SUMSQ_W-1:0]       smin_reg;
    logic [ROOT_W-1:0]        rmax;
    logic [ROOT_W-1:0]        rmin;
    geom_t                    gd_reg [ROOT_W];
    geom_t                    g5;
    item_t                    it5_reg;
    logic [OPND_W-1:0]        tmax_reg;
    logic [OPND_W-1:0]        tmin_reg;
    logic [OPND_W-1:0]        tmax_next;
    logic [OPND_W-1:0]        tmin_next;
    logic signed [ANG_W-1:0]  ang_a;
    logic signed [ANG_W-1:0]  ang_b;
    logic signed [ANG_W-1:0]  ang_c;
    logic signed [ANG_W-1:0]  ang_d;
    logic signed [ANG_W-1:0]  ang_zx;
    logic signed [ANG_W-1:0]  ang_zn;
    region_t                  rg_reg [ATAN_LAT];
    logic signed [SUM_W-1:0]  amin_next;
    logic signed [SUM_W-1:0]  amax_next;
    logic signed [SUM_W-1:0]  amin_reg;
    logic signed [SUM_W-1:0]  amax_reg;
    logic signed [SUM_W-1:0]  zmx_reg;
    logic signed [SUM_W-1:0]  zmn_reg;
    logic signed [SUM_W-1:0]  sa;
    logic signed [SUM_W-1:0]  sb;
    logic signed [SUM_W-1:0]  sc;
    logic signed [SUM_W-1:0]  sd;
    logic signed [OUT_W-1:0]  zmx_out_reg;
    logic signed [OUT_W-1:0]  zmn_out_reg;
    logic signed [OUT_W-1:0]  amx_out_reg;
    logic signed [OUT_W-1:0]  amn_out_reg;

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] a);
        logic signed [SUM_W-1:0] r;
        r = (a + RND) >>> SH;
        if (r > OMAX)
            r = OMAX;
        else if (r < OMIN)
            r = OMIN;
        return r[OUT_W-1:0];
    endfunction

    assign badv     = !vld_reg[LAT-1] || pop;
    assign q_pop    = badv && !q_empty;
    assign empty    = !vld_reg[LAT-1];
    assign vld_next = badv ? {vld_reg[LAT-2:0], q_pop} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign leg[0] = q_item.d1[DIST_W-1:2];
    assign leg[1] = q_item.d2[DIST_W-1:2];
    assign leg[2] = q_item.d3[DIST_W-1:2];
    assign leg[3] = q_item.d4[DIST_W-1:2];

    // squares of the four legs, then corner sums, then max and min
    always_ff @(posedge clk)
    begin
        if (badv)
        begin
            it1_reg <= q_item;
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= {{(SQR_W-LEG_W){1'b0}}, leg[i]} * {{(SQR_W-LEG_W){1'b0}}, leg[i]};
            mn12_reg <= (q_item.d1 < q_item.d2) ? q_item.d1 : q_item.d2;
            mn34_reg <= (q_item.d3 < q_item.d4) ? q_item.d3 : q_item.d4;

            g2_reg.it    <= it1_reg;
            g2_reg.min12 <= mn12_reg;
            g2_reg.min34 <= mn34_reg;
            g2_reg.tover <= (mn12_reg < mn34_reg) ? mn12_reg : mn34_reg;
            sum_reg[0]   <= SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[2]);
            sum_reg[1]   <= SUMSQ_W'(sq_reg[1]) + SUMSQ_W'(sq_reg[2]);
            sum_reg[2]   <= SUMSQ_W'(sq_reg[1]) + SUMSQ_W'(sq_reg[3]);
            sum_reg[3]   <= SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[3]);

            g3_reg   <= g2_reg;
            mx01_reg <= (sum_reg[1] > sum_reg[0]) ? sum_reg[1] : sum_reg[0];
            mn01_reg <= (sum_reg[1] < sum_reg[0]) ? sum_reg[1] : sum_reg[0];
            mx23_reg <= (sum_reg[3] > sum_reg[2]) ? sum_reg[3] : sum_reg[2];
            mn23_reg <= (sum_reg[3] < sum_reg[2]) ? sum_reg[3] : sum_reg[2];

            g4_reg   <= g3_reg;
            smax_reg <= (mx23_reg > mx01_reg) ? mx23_reg : mx01_reg;
            smin_reg <= (mn23_reg < mn01_reg) ? mn23_reg : mn01_reg;

            gd_reg[0] <= g4_reg;
            for (int i = 1; i < ROOT_W; i++)
                gd_reg[i] <= gd_reg[i-1];
        end
    end

    eab_sqrt u_sqrt_max (
        .clk  (clk),
        .en   (badv),
        .rad  (smax_reg),
        .root (rmax)
    );

    eab_sqrt u_sqrt_min (
        .clk  (clk),
        .en   (badv),
        .rad  (smin_reg),
        .root (rmin)
    );

    assign g5 = gd_reg[ROOT_W-1];

    always_comb
    begin
        tmax_next = {rmax, 2'b00};
        tmin_next = {rmin, 2'b00};
        if (g5.it.xo && g5.it.yo)
            tmin_next = {rmin, 2'b00};
        else if (g5.it.xo)
            tmin_next = OPND_W'(g5.min12);
        else if (g5.it.yo)
            tmin_next = OPND_W'(g5.min34);
        else
        begin
            tmin_next = '0;
            tmax_next = OPND_W'(g5.tover);
        end
    end

    always_ff @(posedge clk)
    begin
        if (badv)
        begin
            it5_reg   <= g5.it;
            tmax_reg  <= tmax_next;
            tmin_reg  <= tmin_next;
            rg_reg[0] <= it5_reg.rg;
            for (int i = 1; i < ATAN_LAT; i++)
                rg_reg[i] <= rg_reg[i-1];
        end
    end

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_a (
        .clk (clk), .en (badv),
        .num (OPND_W'(it5_reg.d3)), .den (OPND_W'(it5_reg.d1)), .ang (ang_a)
    );

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_b (
        .clk (clk), .en (badv),
        .num (OPND_W'(it5_reg.d3)), .den (OPND_W'(it5_reg.d2)), .ang (ang_b)
    );

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_c (
        .clk (clk), .en (badv),
        .num (OPND_W'(it5_reg.d4)), .den (OPND_W'(it5_reg.d2)), .ang (ang_c)
    );

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_d (
        .clk (clk), .en (badv),
        .num (OPND_W'(it5_reg.d4)), .den (OPND_W'(it5_reg.d1)), .ang (ang_d)
    );

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_zx (
        .clk (clk), .en (badv),
        .num (tmax_reg), .den (OPND_W'(it5_reg.den)), .ang (ang_zx)
    );

    eab_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_zn (
        .clk (clk), .en (badv),
        .num (tmin_reg), .den (OPND_W'(it5_reg.den)), .ang (ang_zn)
    );

    assign sa = SUM_W'(ang_a);
    assign sb = SUM_W'(ang_b);
    assign sc = SUM_W'(ang_c);
    assign sd = SUM_W'(ang_d);

    always_comb
    begin
        amin_next = '0;
        amax_next = TWO_PI;
        case (rg_reg[ATAN_LAT-1].xr)
            XR_EQ_POS:
            begin
                case (rg_reg[ATAN_LAT-1].yr)
                    YR_MID:  begin amin_next = HALF_S;    amax_next = THREE_H;   end
                    YR_HI:   begin amin_next = PI_S + sb; amax_next = THREE_H;   end
                    default: begin amin_next = HALF_S;    amax_next = PI_S - sc; end
                endcase
            end
            XR_EQ_NEG:
            begin
                case (rg_reg[ATAN_LAT-1].yr)
                    YR_MID:  begin amin_next = -HALF_S;   amax_next = HALF_S;      end
                    YR_HI:   begin amin_next = THREE_H;   amax_next = TWO_PI - sa; end
                    default: begin amin_next = sd;        amax_next = HALF_S;      end
                endcase
            end
            XR_ABOVE:
            begin
                case (rg_reg[ATAN_LAT-1].yr)
                    YR_MID:  begin amin_next = PI_S - sa; amax_next = PI_S + sd; end
                    YR_HI:   begin amin_next = PI_S + sb; amax_next = PI_S + sd; end
                    default: begin amin_next = PI_S - sa; amax_next = PI_S - sc; end
                endcase
            end
            XR_BELOW:
            begin
                case (rg_reg[ATAN_LAT-1].yr)
                    YR_MID:  begin amin_next = -sc;         amax_next = sb;          end
                    YR_HI:   begin amin_next = TWO_PI - sc; amax_next = TWO_PI - sa; end
                    default: begin amin_next = sd;          amax_next = sb;          end
                endcase
            end
            default:
            begin
                case (rg_reg[ATAN_LAT-1].yr)
                    YR_MID:  begin amin_next = '0;        amax_next = TWO_PI;      end
                    YR_HI:   begin amin_next = PI_S + sb; amax_next = TWO_PI - sa; end
                    default: begin amin_next = sd;        amax_next = PI_S - sc;   end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (badv)
        begin
            amin_reg    <= amin_next;
            amax_reg    <= amax_next;
            zmx_reg     <= SUM_W'(ang_zx);
            zmn_reg     <= SUM_W'(ang_zn);
            zmx_out_reg <= to_out(zmx_reg);
            zmn_out_reg <= to_out(zmn_reg);
            amx_out_reg <= to_out(amax_reg);
            amn_out_reg <= to_out(amin_reg);
        end
    end

    assign zenith_max  = zmx_out_reg;
    assign zenith_min  = zmn_out_reg;
    assign azimuth_max = amx_out_reg;
    assign azimuth_min = amn_out_reg;

endmodule

`default_nettype wire

// File: rtl/core/emission_angle_bounds.sv
// Top level of the emission angle bounds block.
//
// Input channel: a point (pos_x, pos_y, height_z) and a square side length
// side_len enter as one transaction when push is high and full is low.
// Result channel: zenith_max, zenith_min, azimuth_max and azimuth_min are
// valid while empty is low; pop with empty low takes the transaction.
// Angles are signed with FRACTION_BITS fraction bits, saturated to 20 bits.
// Pipeline from accept to result: two front stages, the queue, four
// corner-distance stages, the 32-stage square root, one select stage, the
// atan units (7 + CORDIC_STEPS stages) and two output stages.
// Throughput: one transaction per cycle while pop does not hold a waiting
// result, set by the fully pipelined square root and CORDIC units.
// Reset clears all valid flags and the queue; no transaction is in flight.
// When the receiver holds pop low with a result waiting, the back end freezes,
// the queue fills behind it and full rises once the front end cannot advance.
`default_nettype none

module emission_angle_bounds #(
    parameter int FRACTION_BITS = eab_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = eab_pkg::CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH   = eab_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [eab_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [eab_pkg::COORD_W-1:0] pos_y,
    input  wire logic [eab_pkg::LEN_W-1:0]         height_z,
    input  wire logic [eab_pkg::LEN_W-1:0]         side_len,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [eab_pkg::OUT_W-1:0]       zenith_max,
    output logic signed [eab_pkg::OUT_W-1:0]       zenith_min,
    output logic signed [eab_pkg::OUT_W-1:0]       azimuth_max,
    output logic signed [eab_pkg::OUT_W-1:0]       azimuth_min
);
    import eab_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_wdata;
    item_t q_rdata;

    eab_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .height_z (height_z),
        .side_len (side_len),
        .q_push   (q_push),
        .q_item   (q_wdata),
        .q_full   (q_full)
    );

    eab_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    eab_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .zenith_max  (zenith_max),
        .zenith_min  (zenith_min),
        .azimuth_max (azimuth_max),
        .azimuth_min (azimuth_min)
    );

endmodule

`default_nettype wire
